@@ design/sbh_pkg.sv @@
// Package for the SHA-256 byte stream hasher: transfer types, queue sizing,
// round constants, initial hash and the SHA-256 mixing functions.
// No dependencies.
package sbh_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} item_t;

	typedef struct packed {
		logic [63:0] digest_word_0;
		logic [63:0] digest_word_1;
		logic [63:0] digest_word_2;
		logic [63:0] digest_word_3;
	} digest_t;

	// head of the front queue as seen by the back end
	typedef struct packed {
		logic       avail;
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_end;
	} q_head_t;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] K_TAB [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_TAB [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
		return (x >> r) | (x << (32 - r));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

@@ design/sha256_byte_stream_hasher_core.sv @@
// Top level of the SHA-256 byte stream hasher: front queue plus back end.
// Depends on sbh_pkg, sbh_front and sbh_back.
//
// Input channel (item_valid / item_stall / item): one message byte per
// transfer, with byte_present and message_end flags. Items with neither flag
// are taken and have no effect. Output channel (digest_valid / digest_stall /
// digest): one 256-bit digest, as four big-endian 64-bit words, for each
// transfer that carries message_end.
// The back end takes queued bytes only while idle and shifts each into its
// block register; each full 64-byte block adds a compression (64 rounds,
// one finalize). An end item adds padding and one or two compressions.
// A four-entry queue lets bytes arrive while a compression runs;
// item_stall rises when it is full.
// Reset clears the queue and loads the initial hash; the digest register
// holds its word while digest_stall is high, and a finished digest waits in
// the finalize step until that register is free.
module sha256_byte_stream_hasher_core
	import sbh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    digest_valid,
	input  logic    digest_stall,
	output digest_t digest
);

	q_head_t head;
	logic    pop;

	sbh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.pop        (pop),
		.head       (head)
	);

	sbh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

endmodule

@@ design/sbh_front.sv @@
// Front end: takes input transfers, drops items that carry neither a byte
// nor an end mark, and queues the rest for the back end. Uses sbh_pkg.
module sbh_front
	import sbh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	input  logic    pop,
	output q_head_t head
);

	item_t          q_mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;
	logic           do_pop;

	assign item_stall = (count_q == (QAW+1)'(QDEPTH));
	assign push       = item_valid && !item_stall && (item.byte_present || item.message_end);
	assign do_pop     = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_comb begin
		head.avail     = (count_q != '0);
		head.data_byte = q_mem_q[rd_ptr_q].data_byte;
		head.has_byte  = q_mem_q[rd_ptr_q].byte_present;
		head.is_end    = q_mem_q[rd_ptr_q].message_end;
	end

endmodule

@@ design/sbh_back.sv @@
// Back end: 64-byte block shift register doubling as the message schedule,
// padding sequencer, one-round-per-cycle compression and digest register.
// Uses sbh_pkg.
module sbh_back
	import sbh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  q_head_t head,
	output logic    pop,
	output logic    digest_valid,
	input  logic    digest_stall,
	output digest_t digest
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COMP = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_PAD  = 2'd3;

	logic [1:0]   state_q;
	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [63:0]  bitlen_q;
	logic [31:0]  hash_q [8];
	logic [31:0]  v_q [8];
	logic [5:0]   rnd_q;
	logic         end_q;
	logic         final_q;
	logic         pad_first_q;
	logic         len_ok_q;
	logic         out_valid_q;
	digest_t      out_q;

	logic [31:0]  t1, t2, w_new;
	logic [31:0]  sums [8];
	logic [63:0]  len_sh;
	logic [7:0]   pad_byte;
	logic [5:0]   fill_nx;
	logic         out_busy;

	assign pop          = (state_q == ST_IDLE) && head.avail;
	assign digest_valid = out_valid_q;
	assign digest       = out_q;
	assign out_busy     = out_valid_q && digest_stall;
	assign fill_nx      = fill_q + 6'd1;

	always_comb begin
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ K_TAB[rnd_q] + blk_q[511:480];
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = ssig1(blk_q[63:32]) + blk_q[223:192] + ssig0(blk_q[479:448])
			+ blk_q[511:480];
		for (int i = 0; i < 8; i++) begin
			sums[i] = hash_q[i] + v_q[i];
		end
		len_sh = bitlen_q << {fill_q[2:0], 3'b000};
		if (pad_first_q) begin
			pad_byte = PAD_MARK;
		end else if (len_ok_q && (fill_q >= 6'd56)) begin
			pad_byte = len_sh[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (head.avail && head.has_byte) begin
					blk_q <= {blk_q[503:0], head.data_byte};
				end
				if (head.avail && head.has_byte && (fill_q == 6'd63)) begin
					for (int i = 0; i < 8; i++) begin
						v_q[i] <= hash_q[i];
					end
				end
			end
			ST_COMP: begin
				blk_q  <= {blk_q[479:0], w_new};
				v_q[0] <= t1 + t2;
				v_q[1] <= v_q[0];
				v_q[2] <= v_q[1];
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3] + t1;
				v_q[5] <= v_q[4];
				v_q[6] <= v_q[5];
				v_q[7] <= v_q[6];
			end
			ST_FIN: begin
				if (final_q && !out_busy) begin
					out_q.digest_word_0 <= {sums[0], sums[1]};
					out_q.digest_word_1 <= {sums[2], sums[3]};
					out_q.digest_word_2 <= {sums[4], sums[5]};
					out_q.digest_word_3 <= {sums[6], sums[7]};
				end
			end
			ST_PAD: begin
				blk_q <= {blk_q[503:0], pad_byte};
				if (fill_q == 6'd63) begin
					for (int i = 0; i < 8; i++) begin
						v_q[i] <= hash_q[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bitlen_q    <= '0;
			rnd_q       <= '0;
			end_q       <= 1'b0;
			final_q     <= 1'b0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= IV_TAB[i];
			end
		end else begin
			if ((state_q == ST_FIN) && final_q && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !digest_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.avail) begin
						if (head.has_byte) begin
							fill_q   <= fill_nx;
							bitlen_q <= bitlen_q + 64'd8;
							if (fill_q == 6'd63) begin
								state_q     <= ST_COMP;
								rnd_q       <= '0;
								final_q     <= 1'b0;
								end_q       <= head.is_end;
								pad_first_q <= 1'b1;
							end else if (head.is_end) begin
								state_q     <= ST_PAD;
								pad_first_q <= 1'b1;
								len_ok_q    <= (fill_nx < 6'd56);
							end
						end else if (head.is_end) begin
							state_q     <= ST_PAD;
							pad_first_q <= 1'b1;
							len_ok_q    <= (fill_q < 6'd56);
						end
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (final_q) begin
						if (!out_busy) begin
							bitlen_q    <= '0;
							state_q     <= ST_IDLE;
							for (int i = 0; i < 8; i++) begin
								hash_q[i] <= IV_TAB[i];
							end
						end
					end else begin
						for (int i = 0; i < 8; i++) begin
							hash_q[i] <= sums[i];
						end
						if (end_q) begin
							end_q    <= 1'b0;
							len_ok_q <= 1'b1;
							state_q  <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					fill_q      <= fill_nx;
					pad_first_q <= 1'b0;
					if (fill_q == 6'd63) begin
						state_q <= ST_COMP;
						rnd_q   <= '0;
						final_q <= len_ok_q;
						end_q   <= !len_ok_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/sbh_checker.sv @@
// Port-level checks for the SHA-256 byte stream hasher, bound to the top.
// Depends on sbh_pkg and sha256_byte_stream_hasher_core.
module sbh_checker
	import sbh_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    digest_valid,
	input logic    digest_stall,
	input digest_t digest
);

	logic [3:0] pend_q;
	logic       end_xfer;
	logic       dig_xfer;

	assign end_xfer = item_valid && !item_stall && item.message_end;
	assign dig_xfer = digest_valid && !digest_stall;

	// ends taken but digests not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (end_xfer && !dig_xfer) begin
			pend_q <= pend_q + 4'd1;
		end else if (dig_xfer && !end_xfer) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_digest_owed: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (pend_q != 4'd0))
		else $error("digest shown with no end transfer outstanding");

	a_no_instant_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(end_xfer && (pend_q == 4'd0)) |=> !digest_valid)
		else $error("digest appeared one cycle after end transfer");

	a_digest_held: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && digest_stall) |=> (digest_valid && $stable(digest)))
		else $error("stalled digest changed");

	a_valid_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(digest_valid) |-> $past(!digest_stall))
		else $error("digest_valid dropped without a transfer");

endmodule

bind sha256_byte_stream_hasher_core sbh_checker u_sbh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.digest_valid (digest_valid),
	.digest_stall (digest_stall),
	.digest       (digest)
);
